FILE: rtl/tile_selective_invert_macros.svh
// Assertion macros used by the tile selective invert RTL.
`ifndef TILE_SELECTIVE_INVERT_MACROS_SVH
`define TILE_SELECTIVE_INVERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tile selective invert: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define TSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tile selective invert: next-cycle check failed");

`endif

FILE: rtl/tsi_pkg.sv
// Types, constants, microcode table and helpers of the tile selective invert block.
package tsi_pkg;

    localparam int MAX_TILE_SIDE_DEF = 8;
    localparam int PIX_W             = 8;
    localparam int SIDE_W            = 4;
    localparam int LIMIT_W           = 7;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 7;

    localparam logic [PIX_W-1:0] BLACK_LEVEL = 8'd0;
    localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_LIMIT = 2'd2;

    localparam logic [SIDE_W-1:0]  TILE_COLS_RST   = 4'd8;
    localparam logic [SIDE_W-1:0]  TILE_ROWS_RST   = 4'd8;
    localparam logic [LIMIT_W-1:0] BLACK_LIMIT_RST = 7'd32;

    // microprogram step addresses
    typedef logic [1:0] t_step;
    localparam t_step STEP_LOAD = 2'd0;
    localparam t_step STEP_READ = 2'd1;
    localparam t_step STEP_EMIT = 2'd2;
    localparam t_step STEP_END  = 2'd3;

    // branch conditions
    typedef enum logic [1:0] {
        COND_NEVER      = 2'd0,
        COND_ALWAYS     = 2'd1,
        COND_TILE_OPEN  = 2'd2,
        COND_DRAIN_MORE = 2'd3
    } t_cond;

    typedef struct packed {
        logic  take_in;  // wait for and accept an input item
        logic  rd_mem;   // read the tile store at the drain index
        logic  emit;     // wait for the output slot and load it
        logic  clr;      // clear fill, black count and drain index
        t_cond cond;     // branch condition
        t_step target;   // branch target
    } t_ctrl;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '0;
        unique case (step)
            STEP_LOAD: begin
                w.take_in = 1'b1;
                w.cond    = COND_TILE_OPEN;
                w.target  = STEP_LOAD;
            end
            STEP_READ: begin
                w.rd_mem = 1'b1;
                w.cond   = COND_NEVER;
                w.target = STEP_LOAD;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_DRAIN_MORE;
                w.target = STEP_READ;
            end
            STEP_END: begin
                w.clr    = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_LOAD;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    // zero reads as one, above the maximum reads as the maximum
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] side,
                                                     input logic [SIDE_W-1:0] max_side);
        logic [SIDE_W-1:0] s;
        s = side;
        if (side == '0) begin
            s = {{(SIDE_W-1){1'b0}}, 1'b1};
        end else if (side > max_side) begin
            s = max_side;
        end
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] flip_pixel(input logic [PIX_W-1:0] v,
                                                    input logic flip);
        logic [PIX_W-1:0] r;
        r = v;
        if (flip && v == BLACK_LEVEL) begin
            r = WHITE_LEVEL;
        end else if (flip && v == WHITE_LEVEL) begin
            r = BLACK_LEVEL;
        end
        return r;
    endfunction

endpackage

FILE: rtl/tsi_pix_in_if.sv
// Input pixel channel of the tile selective invert block.
interface tsi_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic [tsi_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

FILE: rtl/tsi_pix_out_if.sv
// Output pixel channel of the tile selective invert block.
interface tsi_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [tsi_pkg::PIX_W-1:0]  pixel_out;
    logic                       tile_flipped;
    logic                       tile_last;

    modport source (output valid, output pixel_out, output tile_flipped, output tile_last,
                    input ready);
    modport sink   (input valid, input pixel_out, input tile_flipped, input tile_last,
                    output ready);
endinterface

FILE: rtl/tsi_cfg_if.sv
// Configuration write channel of the tile selective invert block.
interface tsi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsi_pkg::CFG_IDX_W-1:0]   index;
    logic [tsi_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tile_selective_invert.sv
// Tile selective invert: buffers one tile, then drains it, flipped when its black count exceeds black_limit.
//
// Channels: i_in carries grey pixels of one tile, row by row; o_out returns the
// whole tile in the same order with tile_flipped on every pixel and tile_last on
// the final one; i_cfg writes tile_cols, tile_rows and black_limit (index 0..2,
// other indexes ignored). i_cfg is always ready; write it only while idle.
// Flow: while loading, i_in is ready and a pixel is taken whenever it is valid. After
// the last pixel of a tile the tile store is drained pixel by pixel, each with a store
// read step and then an output load step that waits for a free output slot; a wrap-up
// step then clears the tile. The single-port tile store is why reads and output loads
// take separate steps; input is held off while draining and during wrap-up.
// Reset clears the step counter, fill, black count, drain index and output valid and
// reloads the registers with 8, 8 and 32; tile store contents are left as they are.
// A stalled receiver holds the current result in the output register and the
// sequencer waits in its emit step; nothing is lost or repeated.
`include "tile_selective_invert_macros.svh"

module tile_selective_invert #(
    parameter int MAX_TILE_SIDE = tsi_pkg::MAX_TILE_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsi_pix_in_if.sink    i_in,
    tsi_pix_out_if.source o_out,
    tsi_cfg_if.sink       i_cfg
);

    localparam int DEPTH = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [tsi_pkg::SIDE_W-1:0] MAX_SIDE = tsi_pkg::SIDE_W'(MAX_TILE_SIDE);

    // configuration registers
    logic [tsi_pkg::SIDE_W-1:0]  r_cols;
    logic [tsi_pkg::SIDE_W-1:0]  r_rows;
    logic [tsi_pkg::LIMIT_W-1:0] r_limit;

    // sequencer and datapath
    tsi_pkg::t_step              r_step, n_step;
    tsi_pkg::t_ctrl              ctrl;
    logic [CW-1:0]               r_fill;    // pixels stored for the current tile
    logic [tsi_pkg::LIMIT_W-1:0] r_black;   // black pixels seen
    logic [CW-1:0]               r_cnt;     // pixels to drain
    logic [CW-1:0]               r_rd;      // drain index
    logic                        r_flip;
    logic [tsi_pkg::PIX_W-1:0]   r_rdata;
    logic [tsi_pkg::PIX_W-1:0]   r_store [DEPTH];

    // output slot
    logic                        r_o_valid;
    logic [tsi_pkg::PIX_W-1:0]   r_o_pixel;
    logic                        r_o_flip;
    logic                        r_o_last;

    logic                        in_acc;
    logic                        slot_free;
    logic                        fire;
    logic                        cond_hit;
    logic [7:0]                  tile_size;
    logic [7:0]                  count_next;
    logic                        tile_open;
    logic                        drain_last;
    logic [tsi_pkg::LIMIT_W-1:0] black_next;

    assign ctrl = tsi_pkg::ucode(r_step);

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = ctrl.take_in;
    assign in_acc      = i_in.valid && ctrl.take_in;
    assign slot_free   = !r_o_valid || o_out.ready;

    // a step fires once whatever it waits for has happened
    assign fire = (!ctrl.take_in || i_in.valid) && (!ctrl.emit || slot_free);

    assign tile_size  = 8'(tsi_pkg::clamp_side(r_cols, MAX_SIDE))
                      * 8'(tsi_pkg::clamp_side(r_rows, MAX_SIDE));
    assign count_next = 8'(r_fill) + 8'd1;
    assign tile_open  = count_next < tile_size;
    assign drain_last = (8'(r_rd) + 8'd1) == 8'(r_cnt);
    assign black_next = r_black
                      + tsi_pkg::LIMIT_W'(i_in.pixel_in == tsi_pkg::BLACK_LEVEL);

    always_comb begin
        unique case (ctrl.cond)
            tsi_pkg::COND_NEVER:      cond_hit = 1'b0;
            tsi_pkg::COND_ALWAYS:     cond_hit = 1'b1;
            tsi_pkg::COND_TILE_OPEN:  cond_hit = tile_open;
            tsi_pkg::COND_DRAIN_MORE: cond_hit = !drain_last;
            default:                  cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (fire) begin
            n_step = cond_hit ? ctrl.target : r_step + 2'd1;
        end
    end

    // config writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= tsi_pkg::TILE_COLS_RST;
            r_rows  <= tsi_pkg::TILE_ROWS_RST;
            r_limit <= tsi_pkg::BLACK_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tsi_pkg::REG_TILE_COLS:   r_cols  <= i_cfg.data[tsi_pkg::SIDE_W-1:0];
                tsi_pkg::REG_TILE_ROWS:   r_rows  <= i_cfg.data[tsi_pkg::SIDE_W-1:0];
                tsi_pkg::REG_BLACK_LIMIT: r_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // tile store, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_store[r_fill[AW-1:0]] <= i_in.pixel_in;
        end
        if (ctrl.rd_mem) begin
            r_rdata <= r_store[r_rd[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= tsi_pkg::STEP_LOAD;
            r_fill  <= '0;
            r_black <= '0;
            r_rd    <= '0;
        end else begin
            r_step <= n_step;
            if (in_acc) begin
                r_black <= black_next;
                r_fill  <= r_fill + CW'(1);
            end
            if (ctrl.emit && fire) begin
                r_rd <= r_rd + CW'(1);
            end
            if (ctrl.clr) begin
                r_fill  <= '0;
                r_black <= '0;
                r_rd    <= '0;
            end
        end
    end

    // tile verdict and length are latched with the closing pixel
    always_ff @(posedge i_clk) begin
        if (in_acc && !tile_open) begin
            r_flip <= black_next > r_limit;
            r_cnt  <= CW'(count_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ctrl.emit && fire) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit && fire) begin
            r_o_pixel <= tsi_pkg::flip_pixel(r_rdata, r_flip);
            r_o_flip  <= r_flip;
            r_o_last  <= drain_last;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.pixel_out    = r_o_pixel;
    assign o_out.tile_flipped = r_o_flip;
    assign o_out.tile_last    = r_o_last;

    // the drain index never runs past the latched tile length
    `TSI_ASSERT_NOW(a_rd_in_range, i_clk, i_rst_n, r_step == tsi_pkg::STEP_READ, r_rd < r_cnt)
    // fill never reaches the store depth while loading
    `TSI_ASSERT_NOW(a_fill_in_range, i_clk, i_rst_n, r_step == tsi_pkg::STEP_LOAD,
                    32'(r_fill) < DEPTH)
    // the final drain load shows up as a last result
    `TSI_ASSERT_NEXT(a_last_out, i_clk, i_rst_n,
                     r_step == tsi_pkg::STEP_EMIT && fire && drain_last,
                     r_o_valid && r_o_last)
    // wrap-up leaves a clean tile
    `TSI_ASSERT_NEXT(a_clean_start, i_clk, i_rst_n, r_step == tsi_pkg::STEP_END,
                     r_fill == '0 && r_black == '0 && r_step == tsi_pkg::STEP_LOAD)

endmodule
